/* rtl/spq_pkg.sv */
// Shared types, sizes and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int PRIORITY_WIDTH = 8;
   localparam int PAYLOAD_WIDTH  = 32;
   localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);
   localparam int KIND_WIDTH     = 2;
   localparam int STATUS_WIDTH   = 2;

   localparam int REQ_DATA_WIDTH = ((PRIORITY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH =
      ((PRIORITY_WIDTH + PAYLOAD_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
   localparam int REQ_PAD_WIDTH  = REQ_DATA_WIDTH - PRIORITY_WIDTH - PAYLOAD_WIDTH;
   localparam int RSP_PAD_WIDTH  =
      RSP_DATA_WIDTH - PRIORITY_WIDTH - PAYLOAD_WIDTH - COUNT_WIDTH;

   typedef logic [KIND_WIDTH-1:0]     req_kind_type;
   typedef logic [STATUS_WIDTH-1:0]   status_type;
   typedef logic [PRIORITY_WIDTH-1:0] priority_type;
   typedef logic [PAYLOAD_WIDTH-1:0]  payload_type;
   typedef logic [COUNT_WIDTH-1:0]    count_type;

   localparam req_kind_type REQ_ENQUEUE = 2'd0;
   localparam req_kind_type REQ_DEQUEUE = 2'd1;
   localparam req_kind_type REQ_PEEK    = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic         valid;
      priority_type prio;
      payload_type  payload;
   } entry_type;

   typedef struct packed {
      logic         insert;
      logic         remove;
      priority_type prio;
      payload_type  payload;
   } cell_cmd_type;

endpackage
`default_nettype wire

/* rtl/spq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts left or right, or loads the new one.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  spq_pkg::cell_cmd_type  cmd,
   input  spq_pkg::entry_type     left_entry,
   input  wire                    left_keep,
   input  spq_pkg::entry_type     right_entry,
   output spq_pkg::entry_type     entry,
   output logic                   keep
);
   import spq_pkg::*;

   logic         valid_ff, valid_in;
   priority_type prio_ff, prio_in;
   payload_type  payload_ff, payload_in;

   assign keep  = valid_ff && (prio_ff <= cmd.prio);
   assign entry = '{valid: valid_ff, prio: prio_ff, payload: payload_ff};

   always_comb begin
      valid_in   = valid_ff;
      prio_in    = prio_ff;
      payload_in = payload_ff;
      priority if (cmd.insert && !keep && left_keep) begin
         valid_in   = 1'b1;
         prio_in    = cmd.prio;
         payload_in = cmd.payload;
      end else if (cmd.insert && !keep) begin
         valid_in   = left_entry.valid;
         prio_in    = left_entry.prio;
         payload_in = left_entry.payload;
      end else if (cmd.remove) begin
         valid_in   = right_entry.valid;
         prio_in    = right_entry.prio;
         payload_in = right_entry.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prio_ff    <= prio_in;
      payload_ff <= payload_in;
   end

endmodule
`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Top level: sorted minimum-priority queue built as a chain of slot cells.
//
//   channel | direction | tuser            | tdata (lowest bit up)
//   req     | in        | req_type         | in_priority, in_payload
//   rsp     | out       | status           | out_priority, out_payload, entry_count
//
// One request per cycle while the response register is empty or being drained; each
// request passes through the chain and its result appears in the response register on the next cycle.
// Every cell compares against the new priority in parallel and shifts in one step.
// A request is taken while the response register is empty or being drained.
// Synchronous reset empties every slot and clears the count.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [spq_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,  // in_priority, in_payload
   input  wire  [spq_pkg::KIND_WIDTH-1:0]        req_tuser,  // req_type
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [spq_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,  // out_priority, out_payload, entry_count
   output logic [spq_pkg::STATUS_WIDTH-1:0]      rsp_tuser   // status
);
   import spq_pkg::*;

   localparam int LAST = QUEUE_DEPTH - 1;

   logic         accept;
   req_kind_type req_kind;
   priority_type req_prio;
   payload_type  req_payload;
   logic         full, empty;
   cell_cmd_type cmd;

   entry_type              chain_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] chain_keep;
   logic [QUEUE_DEPTH-1:0] chain_valid;

   logic         rsp_valid_ff, rsp_valid_in;
   status_type   rsp_status_ff, rsp_status_in;
   priority_type rsp_prio_ff, rsp_prio_in;
   payload_type  rsp_payload_ff, rsp_payload_in;
   count_type    count_ff, count_in;

   assign req_kind    = req_tuser;
   assign req_prio    = req_tdata[PRIORITY_WIDTH-1:0];
   assign req_payload = req_tdata[PRIORITY_WIDTH +: PAYLOAD_WIDTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = chain_entry[LAST].valid;
   assign empty      = !chain_entry[0].valid;

   assign cmd.insert  = accept && (req_kind == REQ_ENQUEUE) && !full;
   assign cmd.remove  = accept && (req_kind == REQ_DEQUEUE) && !empty;
   assign cmd.prio    = req_prio;
   assign cmd.payload = req_payload;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_keep;
      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = chain_entry[i-1];
         assign left_keep  = chain_keep[i-1];
      end
      if (i == LAST) begin : g_tail
         assign right_entry = '0;
      end else begin : g_link
         assign right_entry = chain_entry[i+1];
      end
      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (chain_entry[i]),
         .keep        (chain_keep[i])
      );
      assign chain_valid[i] = chain_entry[i].valid;
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_payload_in = rsp_payload_ff;
      count_in       = count_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STATUS_OK;
         rsp_prio_in    = '0;
         rsp_payload_in = '0;
         unique case (req_kind)
            REQ_ENQUEUE: begin
               if (full) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
               if (empty) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_prio_in    = chain_entry[0].prio;
                  rsp_payload_in = chain_entry[0].payload;
                  if (req_kind == REQ_DEQUEUE) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_WIDTH{1'b0}}, count_ff, rsp_payload_ff, rsp_prio_ff};

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(chain_valid) == int'(count_ff))
      else $error("entry count differs from occupied slots");

   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (chain_valid & (chain_valid + 1'b1)) == '0)
      else $error("occupied slots do not form a prefix");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      chain_entry[1].valid |-> (chain_entry[0].prio <= chain_entry[1].prio))
      else $error("front of chain out of order");

   a_transfer_answered: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for sorted_priority_queue: directed and random requests against a local queue model.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import spq_pkg::*;

   localparam req_kind_type REQ_UNUSED = 2'd3;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      priority_type prio;
      payload_type  payload;
   } stored_entry_type;

   typedef struct {
      status_type   status;
      priority_type prio;
      payload_type  payload;
      count_type    count;
   } queue_response_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_EVERY_FOURTH, RX_LONG_STALLS} rx_pattern_type;
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_type;
   typedef enum {PRIO_FULL, PRIO_NARROW, PRIO_EXTREME} prio_spread_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [KIND_WIDTH-1:0]     req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [STATUS_WIDTH-1:0]   rsp_tuser;

   stored_entry_type   queued_entries[$];
   queue_response_type expected_responses[$];

   int mismatch_count = 0;
   int responses_checked = 0;
   int burst_left = 0;
   int enqueue_sent = 0;
   int dequeue_sent = 0;
   int peek_sent = 0;
   int unused_sent = 0;
   int full_rejects = 0;
   int empty_hits = 0;
   int deepest_fill = 0;

   rx_pattern_type rx_pattern = RX_ALWAYS;
   logic [6:0]     rx_phase = '0;

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Timeout: %0d responses still outstanding", expected_responses.size());
      $display("Test completed with failures");
      $finish;
   end

   // Model of one request: update the stored entries, return the response
   function automatic queue_response_type predict_response(req_kind_type kind,
                                                           priority_type prio,
                                                           payload_type payload);
      queue_response_type rsp;
      stored_entry_type   entry;
      int                 pos;
      rsp.status  = STATUS_OK;
      rsp.prio    = '0;
      rsp.payload = '0;
      if (kind == REQ_ENQUEUE) begin
         if (queued_entries.size() >= QUEUE_DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < queued_entries.size() && queued_entries[pos].prio <= prio) pos++;
            entry.prio    = prio;
            entry.payload = payload;
            queued_entries.insert(pos, entry);
         end
      end else if (kind == REQ_DEQUEUE || kind == REQ_PEEK) begin
         if (queued_entries.size() == 0) begin
            rsp.status = STATUS_EMPTY;
         end else begin
            rsp.prio    = queued_entries[0].prio;
            rsp.payload = queued_entries[0].payload;
            if (kind == REQ_DEQUEUE) void'(queued_entries.pop_front());
         end
      end
      rsp.count = count_type'(queued_entries.size());
      return rsp;
   endfunction

   task automatic send_request(req_kind_type kind, priority_type prio, payload_type payload);
      logic [REQ_DATA_WIDTH-1:0] word;
      queue_response_type        rsp;
      word = '0;
      word[PRIORITY_WIDTH-1:0] = prio;
      word[PRIORITY_WIDTH +: PAYLOAD_WIDTH] = payload;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rsp = predict_response(kind, prio, payload);
      expected_responses.push_back(rsp);
      case (kind)
         REQ_ENQUEUE: enqueue_sent++;
         REQ_DEQUEUE: dequeue_sent++;
         REQ_PEEK:    peek_sent++;
         default:     unused_sent++;
      endcase
      if (rsp.status == STATUS_FULL) full_rejects++;
      if (rsp.status == STATUS_EMPTY) empty_hits++;
      if (queued_entries.size() > deepest_fill) deepest_fill = queued_entries.size();
   endtask

   // Bursts of back-to-back transfers, mostly separated by idle gaps
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic issue(req_kind_type kind, priority_type prio, payload_type payload);
      send_request(kind, prio, payload);
      pace_sender();
   endtask

   task automatic test_empty_queue();
      issue(REQ_DEQUEUE, 8'hFF, 32'hFFFF_FFFF);
      issue(REQ_PEEK, 8'h00, 32'h0000_0000);
      issue(REQ_UNUSED, 8'hA5, 32'h5A5A_A5A5);
   endtask

   // Fill to capacity with extreme and tied priorities, push past full, then peek, send an unused code and dequeue
   task automatic test_fill_to_full();
      priority_type prio;
      payload_type  payload;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         case (i % 4)
            0:       prio = '1;
            1:       prio = '0;
            2:       prio = 8'h80;
            default: prio = priority_type'($urandom);
         endcase
         payload = (i == 0) ? '1 : (i == 1) ? '0 : $urandom;
         issue(REQ_ENQUEUE, prio, payload);
      end
      issue(REQ_ENQUEUE, 8'h00, 32'hDEAD_BEEF);
      issue(REQ_PEEK, 8'h00, 32'h0);
      issue(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF);
      issue(REQ_DEQUEUE, 8'h00, 32'h0);
   endtask

   task automatic test_random_traffic(int total);
      traffic_mix_type mix;
      prio_spread_type spread;
      req_kind_type    kind;
      priority_type    prio;
      int              roll;
      int              sent;
      sent = 0;
      while (sent < total) begin
         mix    = traffic_mix_type'($urandom_range(0, 2));
         spread = prio_spread_type'($urandom_range(0, 2));
         for (int j = $urandom_range(10, 50); j > 0 && sent < total; j--) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
               kind = REQ_UNUSED;
            end else begin
               case (mix)
                  MIX_FILL:  kind = (roll < 85) ? REQ_ENQUEUE :
                                    (roll < 93) ? REQ_DEQUEUE : REQ_PEEK;
                  MIX_DRAIN: kind = (roll < 18) ? REQ_ENQUEUE :
                                    (roll < 85) ? REQ_DEQUEUE : REQ_PEEK;
                  default:   kind = (roll < 50) ? REQ_ENQUEUE :
                                    (roll < 80) ? REQ_DEQUEUE : REQ_PEEK;
               endcase
            end
            case (spread)
               PRIO_NARROW:  prio = priority_type'($urandom_range(0, 3));
               PRIO_EXTREME: prio = $urandom_range(0, 1) ? '1 : '0;
               default:      prio = priority_type'($urandom);
            endcase
            issue(kind, prio, $urandom);
            sent++;
         end
      end
   endtask

   // Receiver back-pressure, switching pattern each time the rx_phase counter wraps
   always @(posedge clock) begin
      rx_phase <= rx_phase + 1'b1;
      if (rx_phase == '0) rx_pattern <= rx_pattern_type'($urandom_range(0, 3));
      case (rx_pattern)
         RX_ALWAYS:       rsp_tready <= 1'b1;
         RX_RANDOM:       rsp_tready <= ($urandom_range(0, 1) == 1);
         RX_EVERY_FOURTH: rsp_tready <= (rx_phase[1:0] == 2'd3);
         default:         rsp_tready <= (rx_phase[4:0] >= 5'd12);
      endcase
   end

   always @(posedge clock) begin : check_responses
      queue_response_type want;
      queue_response_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status  = rsp_tuser;
         got.prio    = rsp_tdata[PRIORITY_WIDTH-1:0];
         got.payload = rsp_tdata[PRIORITY_WIDTH +: PAYLOAD_WIDTH];
         got.count   = rsp_tdata[PRIORITY_WIDTH + PAYLOAD_WIDTH +: COUNT_WIDTH];
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected response: status %0d prio %0h payload %0h count %0d",
                        $realtime, got.status, got.prio, got.payload, got.count);
         end else begin
            want = expected_responses.pop_front();
            responses_checked++;
            if (got.status !== want.status || got.prio !== want.prio ||
                got.payload !== want.payload || got.count !== want.count) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch: expected status %0d prio %0h payload %0h count %0d",
                           $realtime, want.status, want.prio, want.payload, want.count);
                  $display("%0t:           got status %0d prio %0h payload %0h count %0d",
                           $realtime, got.status, got.prio, got.payload, got.count);
               end
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_to_full();
      test_random_traffic(1000);
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d enqueues, %0d dequeues, %0d peeks, %0d unused codes",
               enqueue_sent, dequeue_sent, peek_sent, unused_sent);
      $display("%0d responses checked, depth reached %0d, %0d full, %0d empty, %0d mismatches",
               responses_checked, deepest_fill, full_rejects, empty_hits, mismatch_count);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
`default_nettype wire
